>>> design/qbvs_pkg.sv
// ----------------------------------------------------------------------------
// qbvs_pkg
// Shared types, codes and constants of the quad batch vertex setup block.
// ----------------------------------------------------------------------------
package qbvs_pkg;

  localparam int TEXTURE_SLOTS_DEF   = 32;
  localparam int MAX_BATCH_QUADS_DEF = 65536;

  // operation codes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // record kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic [16:0] LIMIT_RESET = 17'd65536;

  // Q30 angle constants
  localparam logic [35:0] HALF_PI_Q30    = 36'd1686629713;
  localparam logic [35:0] QUARTER_PI_Q30 = 36'd843314856;
  localparam logic [35:0] REDUCE_OFS     = 36'd6 * HALF_PI_Q30 + QUARTER_PI_Q30;

  // exact reciprocals for dividends below 2^30: q = (x * M) >> S
  localparam logic [31:0] RCP_6     = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_120   = 32'(((64'd1 << 37) + 64'd119) / 64'd120);
  localparam logic [31:0] RCP_5040  = 32'(((64'd1 << 43) + 64'd5039) / 64'd5040);
  localparam logic [31:0] RCP_2     = 32'(((64'd1 << 31) + 64'd1) / 64'd2);
  localparam logic [31:0] RCP_24    = 32'(((64'd1 << 35) + 64'd23) / 64'd24);
  localparam logic [31:0] RCP_720   = 32'(((64'd1 << 40) + 64'd719) / 64'd720);
  localparam logic [31:0] RCP_40320 = 32'(((64'd1 << 46) + 64'd40319) / 64'd40320);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_FLUSH,
    S_ALLOC,
    S_REDUCE,
    S_POW,
    S_DIV,
    S_SUM,
    S_VPROD,
    S_CSUM,
    S_COUT,
    S_END
  } state_t;

  // series term divisor: odd terms 3,5,7 then even terms 2,4,6,8
  function automatic logic [31:0] rcp_mult(input logic [2:0] step);
    logic [31:0] m;
    unique case (step)
      3'd0:    m = RCP_6;
      3'd1:    m = RCP_120;
      3'd2:    m = RCP_5040;
      3'd3:    m = RCP_2;
      3'd4:    m = RCP_24;
      3'd5:    m = RCP_720;
      default: m = RCP_40320;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] rcp_shift(input logic [2:0] step);
    logic [5:0] s;
    unique case (step)
      3'd0:    s = 6'd33;
      3'd1:    s = 6'd37;
      3'd2:    s = 6'd43;
      3'd3:    s = 6'd31;
      3'd4:    s = 6'd35;
      3'd5:    s = 6'd40;
      default: s = 6'd46;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

>>> design/quad_batch_vertex_setup.sv
// ----------------------------------------------------------------------------
// quad_batch_vertex_setup
// Sprite batch quad vertex generation: one quad in, four vertices out.
// ----------------------------------------------------------------------------
// Sequence: a draw item searches the slot table one entry at a time, reduces
//   the angle by repeated subtraction, makes 18 passes through the one shared
//   multiplier, then emits its four corners in turn.
// Throughput: one item at a time; begin scene and end scene are items too.
// Reset (synchronous, rst high): empty batch, one slot in use, limit 65536,
//   output empty. The slot id RAM is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module quad_batch_vertex_setup import qbvs_pkg::*; #(
  parameter int TEXTURE_SLOTS   = TEXTURE_SLOTS_DEF,
  parameter int MAX_BATCH_QUADS = MAX_BATCH_QUADS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data,
  // input item
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] size_x,
  input  logic signed [31:0] size_y,
  input  logic signed [15:0] angle,
  input  logic               is_textured,
  input  logic [15:0]        texture_id,
  input  logic [31:0]        color_rgba,
  input  logic [15:0]        tiling,
  // result item
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [31:0] vert_x,
  output logic signed [31:0] vert_y,
  output logic signed [31:0] vert_z,
  output logic               tex_u,
  output logic               tex_v,
  output logic [31:0]        vert_color,
  output logic [4:0]         slot_index,
  output logic [15:0]        vert_tiling,
  output logic [16:0]        flush_quads,
  output logic [5:0]         flush_slots,
  output logic               last
);

  localparam int AW  = $clog2(TEXTURE_SLOTS);
  localparam int SW  = $clog2(TEXTURE_SLOTS + 1);
  localparam int BQW = $clog2(MAX_BATCH_QUADS + 1);
  localparam int CW  = (BQW > 17) ? BQW : 17;

  state_t state, state_next;

  // control state
  logic [16:0]    limit;
  logic [SW-1:0]  slots_used;
  logic [BQW-1:0] batch_quads;

  // latched item
  logic signed [31:0] px, py, pz, sxz, syz;
  logic               tex;
  logic [15:0]        tid;
  logic [31:0]        col;
  logic [15:0]        til;

  // search and slot
  logic [SW-1:0] idx;
  logic [SW-1:0] slot;
  logic          found;

  // angle and series
  logic [35:0]        b_acc;
  logic [3:0]         k_cnt;
  logic [1:0]         quad;
  logic signed [30:0] r_q;
  logic signed [30:0] p2, p3, p4, p5, p6, p7, p8;
  logic [29:0]        tq [7];
  logic signed [32:0] sn, cs;
  logic signed [63:0] vp [4];
  logic signed [63:0] rx, ry;
  logic [2:0]         step;
  logic [1:0]         corner;

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic signed [67:0] qm_full;
  logic [67:0]        dq_full;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;

  logic out_free, out_load, need_flush;
  logic [CW-1:0] lim_ext, lim_eff;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // effective batch limit: zero acts as one, clamp to the batch maximum
  always_comb begin
    lim_ext = CW'(limit);
    if (lim_ext == '0)                       lim_eff = CW'(1);
    else if (lim_ext > CW'(MAX_BATCH_QUADS)) lim_eff = CW'(MAX_BATCH_QUADS);
    else                                     lim_eff = lim_ext;
  end

  assign need_flush = (CW'(batch_quads) >= lim_eff) ||
                      (tex && !found && (slots_used >= SW'(TEXTURE_SLOTS)));

  qbvs_ram #(
    .WIDTH (16),
    .DEPTH (TEXTURE_SLOTS)
  ) u_slot_ids (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tid),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = idx[AW-1:0];
  assign ram_waddr = slots_used[AW-1:0];

  assign prod    = mul_a * mul_b;
  // Q30 product truncated toward zero
  assign qm_full = (prod + (prod[67] ? 68'sd1073741823 : 68'sd0)) >>> 30;
  assign dq_full = $unsigned(prod) >> rcp_shift(step);

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic [29:0] dvd;
    state_next = state;
    in_stall   = 1'b1;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    dvd        = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (operation)
            OP_DRAW: state_next = is_textured ? S_SRCH_RD : S_DECIDE;
            OP_END:  state_next = S_END;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD:  state_next = (idx >= slots_used) ? S_DECIDE : S_SRCH_CMP;
      S_SRCH_CMP: state_next = (ram_rdata == tid) ? S_DECIDE : S_SRCH_RD;
      S_DECIDE:   state_next = need_flush ? S_FLUSH : S_ALLOC;
      S_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        ram_we     = tex && !found && (slots_used < SW'(TEXTURE_SLOTS));
        state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (b_acc < HALF_PI_Q30) state_next = S_POW;
      end
      S_POW: begin
        unique case (step)
          3'd0: begin mul_a = 34'(r_q); mul_b = 34'(r_q); end
          3'd1: begin mul_a = 34'(p2);  mul_b = 34'(r_q); end
          3'd2: begin mul_a = 34'(p2);  mul_b = 34'(p2);  end
          3'd3: begin mul_a = 34'(p4);  mul_b = 34'(r_q); end
          3'd4: begin mul_a = 34'(p4);  mul_b = 34'(p2);  end
          3'd5: begin mul_a = 34'(p6);  mul_b = 34'(r_q); end
          default: begin mul_a = 34'(p4); mul_b = 34'(p4); end
        endcase
        if (step == 3'd6) state_next = S_DIV;
      end
      S_DIV: begin
        unique case (step)
          3'd0: dvd = p3[30] ? 30'(-p3) : p3[29:0];
          3'd1: dvd = p5[30] ? 30'(-p5) : p5[29:0];
          3'd2: dvd = p7[30] ? 30'(-p7) : p7[29:0];
          3'd3: dvd = p2[29:0];
          3'd4: dvd = p4[29:0];
          3'd5: dvd = p6[29:0];
          default: dvd = p8[29:0];
        endcase
        mul_a = $signed({4'b0, dvd});
        mul_b = $signed({2'b0, rcp_mult(step)});
        if (step == 3'd6) state_next = S_SUM;
      end
      S_SUM: state_next = S_VPROD;
      S_VPROD: begin
        unique case (step[1:0])
          2'd0: begin mul_a = 34'(sxz); mul_b = 34'(cs); end
          2'd1: begin mul_a = 34'(syz); mul_b = 34'(sn); end
          2'd2: begin mul_a = 34'(sxz); mul_b = 34'(sn); end
          default: begin mul_a = 34'(syz); mul_b = 34'(cs); end
        endcase
        if (step[1:0] == 2'd3) state_next = S_CSUM;
      end
      S_CSUM: state_next = S_COUT;
      S_COUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = (corner == 2'd3) ? S_IDLE : S_CSUM;
        end
      end
      S_END: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      limit       <= LIMIT_RESET;
      slots_used  <= SW'(1);
      batch_quads <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) limit <= cfg_data;
      if (out_load)               out_valid <= 1'b1;
      else if (!out_stall)        out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && operation == OP_BEGIN) begin
        slots_used  <= SW'(1);
        batch_quads <= '0;
      end
      if (state == S_FLUSH && out_free) begin
        slots_used  <= SW'(1);
        batch_quads <= '0;
      end
      if (ram_we) slots_used <= slots_used + SW'(1);
      if (state == S_COUT && out_free && corner == 2'd3 &&
          batch_quads < BQW'(MAX_BATCH_QUADS)) begin
        batch_quads <= batch_quads + BQW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [32:0] s_sum, c_sum, t3s, t5s, t7s;
  logic               cx_pos, cy_pos;
  logic signed [63:0] rx_adj, ry_adj, rx_sh, ry_sh;
  logic signed [33:0] vx_sum, vy_sum;
  logic [SW+4:0]      slot_ext;
  logic [SW+5:0]      su_ext;
  logic [BQW+16:0]    bq_ext;

  always_comb begin
    t3s   = p3[30] ? -$signed({3'b0, tq[0]}) : $signed({3'b0, tq[0]});
    t5s   = p5[30] ? -$signed({3'b0, tq[1]}) : $signed({3'b0, tq[1]});
    t7s   = p7[30] ? -$signed({3'b0, tq[2]}) : $signed({3'b0, tq[2]});
    s_sum = 33'(r_q) - t3s + t5s - t7s;
    c_sum = 33'sd1073741824 - $signed({3'b0, tq[3]}) + $signed({3'b0, tq[4]})
          - $signed({3'b0, tq[5]}) + $signed({3'b0, tq[6]});
  end

  // corner signs: (-,-), (+,-), (+,+), (-,+)
  assign cx_pos = (corner == 2'd1) || (corner == 2'd2);
  assign cy_pos = corner[1];

  // offset / 2^31 toward zero, then translate
  assign rx_adj = rx + (rx[63] ? 64'sd2147483647 : 64'sd0);
  assign ry_adj = ry + (ry[63] ? 64'sd2147483647 : 64'sd0);
  assign rx_sh  = rx_adj >>> 31;
  assign ry_sh  = ry_adj >>> 31;
  assign vx_sum = 34'(px) + rx_sh[33:0];
  assign vy_sum = 34'(py) + ry_sh[33:0];

  assign slot_ext = {5'b0, slot};
  assign su_ext   = {6'b0, slots_used};
  assign bq_ext   = {17'b0, batch_quads};

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px    <= pos_x;
        py    <= pos_y;
        pz    <= pos_z;
        sxz   <= size_x;
        syz   <= size_y;
        tex   <= is_textured;
        tid   <= texture_id;
        col   <= color_rgba;
        til   <= tiling;
        idx   <= SW'(1);
        slot  <= '0;
        found <= 1'b0;
        k_cnt <= '0;
        b_acc <= 36'($signed({angle, 18'b0})) + REDUCE_OFS;
      end
      S_SRCH_CMP: begin
        if (ram_rdata == tid) begin
          found <= 1'b1;
          slot  <= idx;
        end else begin
          idx <= idx + SW'(1);
        end
      end
      S_FLUSH: begin
        if (out_free) found <= 1'b0;
      end
      S_ALLOC: begin
        if (!tex)             slot <= '0;
        else if (ram_we)      slot <= slots_used;
      end
      S_REDUCE: begin
        step <= '0;
        if (b_acc >= HALF_PI_Q30) begin
          b_acc <= b_acc - HALF_PI_Q30;
          k_cnt <= k_cnt + 4'd1;
        end else begin
          r_q  <= 31'($signed({1'b0, b_acc}) - $signed({1'b0, QUARTER_PI_Q30}));
          quad <= k_cnt[1:0] + 2'd2;
        end
      end
      S_POW: begin
        unique case (step)
          3'd0: p2 <= qm_full[30:0];
          3'd1: p3 <= qm_full[30:0];
          3'd2: p4 <= qm_full[30:0];
          3'd3: p5 <= qm_full[30:0];
          3'd4: p6 <= qm_full[30:0];
          3'd5: p7 <= qm_full[30:0];
          default: p8 <= qm_full[30:0];
        endcase
        step <= (step == 3'd6) ? 3'd0 : step + 3'd1;
      end
      S_DIV: begin
        tq[step] <= dq_full[29:0];
        step     <= (step == 3'd6) ? 3'd0 : step + 3'd1;
      end
      S_SUM: begin
        unique case (quad)
          2'd0: begin sn <= s_sum;  cs <= c_sum;  end
          2'd1: begin sn <= c_sum;  cs <= -s_sum; end
          2'd2: begin sn <= -s_sum; cs <= -c_sum; end
          default: begin sn <= -c_sum; cs <= s_sum; end
        endcase
        step <= '0;
      end
      S_VPROD: begin
        vp[step[1:0]] <= prod[63:0];
        step          <= step + 3'd1;
        corner        <= '0;
      end
      S_CSUM: begin
        rx <= (cx_pos ? vp[0] : -vp[0]) - (cy_pos ? vp[1] : -vp[1]);
        ry <= (cx_pos ? vp[2] : -vp[2]) + (cy_pos ? vp[3] : -vp[3]);
      end
      S_COUT: begin
        if (out_free) corner <= corner + 2'd1;
      end
      default: ;
    endcase

    // result register
    if (out_load) begin
      if (state == S_COUT) begin
        kind        <= KIND_VERTEX;
        vert_x      <= sat32(vx_sum);
        vert_y      <= sat32(vy_sum);
        vert_z      <= pz;
        tex_u       <= cx_pos;
        tex_v       <= cy_pos;
        vert_color  <= col;
        slot_index  <= slot_ext[4:0];
        vert_tiling <= til;
        flush_quads <= '0;
        flush_slots <= '0;
        last        <= (corner == 2'd3);
      end else begin
        kind        <= KIND_FLUSH;
        vert_x      <= '0;
        vert_y      <= '0;
        vert_z      <= '0;
        tex_u       <= 1'b0;
        tex_v       <= 1'b0;
        vert_color  <= '0;
        slot_index  <= '0;
        vert_tiling <= '0;
        flush_quads <= bq_ext[16:0];
        flush_slots <= su_ext[5:0];
        last        <= (state == S_END);
      end
    end
  end

  // ---------------------------------------------------------------- checks
  a_slots_range: assert property (@(posedge clk) disable iff (rst)
    (slots_used >= SW'(1)) && (slots_used <= SW'(TEXTURE_SLOTS)))
    else $error("slots in use out of range");

  a_batch_range: assert property (@(posedge clk) disable iff (rst)
    batch_quads <= BQW'(MAX_BATCH_QUADS))
    else $error("batch count above maximum");

  a_no_white_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (slots_used != '0) && !found)
    else $error("slot table write to white slot or on reuse");

  a_reduced_angle: assert property (@(posedge clk) disable iff (rst)
    (state == S_REDUCE && b_acc < HALF_PI_Q30) |=>
      (r_q >= -31'sd843314856) && (r_q < 31'sd843314857))
    else $error("reduced angle out of range");

endmodule

>>> design/qbvs_ram.sv
// ----------------------------------------------------------------------------
// qbvs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module qbvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
